// ----- src/cmt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the centered master tile layout block.
// Depends on nothing; imported by the controller, the datapath and the top level.

package cmt_pkg;

	localparam int COORD_W    = 16;
	localparam int DIM_W      = 15;
	localparam int CNT_W      = 8;
	localparam int HANDLE_W   = 16;
	localparam int FRAC_W     = 16;
	localparam int PROD_W     = DIM_W + FRAC_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Quotient bits of the tile height divider, one per iteration.
	localparam int QUOT_W    = DIM_W;
	localparam int DIV_CNT_W = $clog2(QUOT_W + 1);

	// Q0.16 value of 0.55, used when the fraction register holds zero.
	localparam logic [FRAC_W-1:0] DEFAULT_FRACTION = 16'd36045;
	localparam logic [CNT_W-1:0]  RESET_MASTERS    = 8'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AREA_X,
		CFG_AREA_Y,
		CFG_AREA_WIDTH,
		CFG_AREA_HEIGHT,
		CFG_MASTER_COUNT,
		CFG_MASTER_FRACTION,
		CFG_PORTRAIT
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_LATCH,
		ST_PREP,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		COL_CENTER,
		COL_LEFT,
		COL_RIGHT
	} col_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic latch;
		logic prep;
		logic step;
		logic finish;
	} cmt_cmd_t;

	typedef struct packed {
		logic first;
		logic oob;
		logic div_done;
	} cmt_status_t;

endpackage

// ----- src/cmt_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencing state machine of the centered master tile layout block.
// Depends on cmt_pkg; drives the datapath through cmt_cmd_t and reads cmt_status_t.

module cmt_ctrl import cmt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	output logic        tile_valid,
	input  logic        tile_stall,
	output cmt_cmd_t    cmd,
	input  cmt_status_t status
);

	state_t state_q, state_d;
	logic   tile_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tile_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				tile_valid_q <= 1'b1;
			end else if (!tile_stall) begin
				tile_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.mul = 1'b1;
				state_d = status.first ? ST_LATCH : ST_PREP;
			end
			ST_LATCH: begin
				cmd.latch = 1'b1;
				state_d   = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = status.oob ? ST_FIN : ST_DIV;
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_d = ST_FIN;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_FIN: begin
				if (!tile_valid_q || !tile_stall) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign tile_valid = tile_valid_q;

	// A new result never overwrites one that is still held.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!tile_valid_q || !tile_stall))
		else $error("result written over a stalled word");

	// A finished tile is presented in the following cycle.
	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> tile_valid_q)
		else $error("finished tile not presented");

endmodule

// ----- src/cmt_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the centered master tile layout block: configuration registers,
// layout state, column selection, iterative height divider and output register.
// Depends on cmt_pkg; controlled by cmt_ctrl through cmt_cmd_t.

module cmt_dp import cmt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [HANDLE_W-1:0]   client_handle,
	input  logic [CNT_W-1:0]      client_count,
	input  logic                  first,
	input  cmt_cmd_t              cmd,
	output cmt_status_t           status,
	output logic [HANDLE_W-1:0]   client_handle_out,
	output logic [COORD_W-1:0]    tile_x,
	output logic [COORD_W-1:0]    tile_y,
	output logic [DIM_W-1:0]      tile_width,
	output logic [DIM_W-1:0]      tile_height,
	output logic                  last
);

	// Configuration registers.
	logic [COORD_W-1:0] area_x_q, area_y_q;
	logic [DIM_W-1:0]   area_width_q, area_height_q;
	logic [CNT_W-1:0]   master_count_q;
	logic [FRAC_W-1:0]  master_fraction_q;
	logic               portrait_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_x_q          <= '0;
			area_y_q          <= '0;
			area_width_q      <= '0;
			area_height_q     <= '0;
			master_count_q    <= RESET_MASTERS;
			master_fraction_q <= DEFAULT_FRACTION;
			portrait_q        <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_AREA_X:          area_x_q          <= cfg_data;
				CFG_AREA_Y:          area_y_q          <= cfg_data;
				CFG_AREA_WIDTH:      area_width_q      <= cfg_data[DIM_W-1:0];
				CFG_AREA_HEIGHT:     area_height_q     <= cfg_data[DIM_W-1:0];
				CFG_MASTER_COUNT:    master_count_q    <= cfg_data[CNT_W-1:0];
				CFG_MASTER_FRACTION: master_fraction_q <= cfg_data[FRAC_W-1:0];
				CFG_PORTRAIT:        portrait_q        <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Area in layout orientation; portrait swaps the axes.
	logic [COORD_W-1:0] ox, oy;
	logic [DIM_W-1:0]   ow, oh;
	logic [FRAC_W-1:0]  frac_eff;

	assign ox       = portrait_q ? area_y_q : area_x_q;
	assign oy       = portrait_q ? area_x_q : area_y_q;
	assign ow       = portrait_q ? area_height_q : area_width_q;
	assign oh       = portrait_q ? area_width_q : area_height_q;
	assign frac_eff = (master_fraction_q == '0) ? DEFAULT_FRACTION : master_fraction_q;

	// Item word and center width product.
	logic [HANDLE_W-1:0] handle_q;
	logic [CNT_W-1:0]    count_q;
	logic                first_q;
	logic [PROD_W-1:0]   prod_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			handle_q <= client_handle;
			count_q  <= client_count;
			first_q  <= first;
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(ow) * PROD_W'(frac_eff);
		end
	end

	// Arrangement state, latched on the first window.
	logic [CNT_W-1:0]   idx_q, total_q, lt_q, rt_q;
	logic [DIM_W-1:0]   cw_q, lw_q;
	logic [COORD_W-1:0] used_c_q, used_l_q, used_r_q;

	logic [DIM_W-1:0] cw_new;
	logic [CNT_W-1:0] stack_new, lt_new;
	logic [CNT_W:0]   stack_inc;

	assign cw_new    = prod_q[PROD_W-1:FRAC_W];
	assign stack_new = (count_q > master_count_q) ? (count_q - master_count_q) : '0;
	assign stack_inc = {1'b0, stack_new} + (CNT_W+1)'(1);
	assign lt_new    = stack_inc[CNT_W:1];

	// Column selection for the current window.
	logic               single, oob_c, last_c, odd;
	logic [CNT_W-1:0]   s_idx, k_idx;
	logic [COORD_W-1:0] lc, used_sel, tx_c, ty_c;
	logic [DIM_W-1:0]   tw_c, rem_c;
	logic [CNT_W-1:0]   div_c;
	logic [CNT_W:0]     idx_inc;
	col_t               col_c;

	assign single   = (master_count_q == '0) || (total_q <= master_count_q);
	assign s_idx    = idx_q - master_count_q;
	assign k_idx    = {1'b0, s_idx[CNT_W-1:1]};
	assign odd      = s_idx[0];
	assign lc       = {1'b0, lw_q} + {1'b0, cw_q};
	assign oob_c    = (idx_q >= total_q);
	assign idx_inc  = {1'b0, idx_q} + (CNT_W+1)'(1);
	assign last_c   = oob_c || (idx_inc == {1'b0, total_q});

	always_comb begin
		col_c = COL_CENTER;
		tx_c  = ox;
		tw_c  = ow;
		div_c = total_q - idx_q;
		if (single) begin
			col_c = COL_CENTER;
		end else if (idx_q < master_count_q) begin
			col_c = COL_CENTER;
			tx_c  = ox + {1'b0, lw_q};
			tw_c  = cw_q;
			div_c = master_count_q - idx_q;
		end else if (!odd) begin
			col_c = COL_LEFT;
			tw_c  = lw_q;
			div_c = (lt_q > k_idx) ? (lt_q - k_idx) : CNT_W'(1);
		end else begin
			col_c = COL_RIGHT;
			tx_c  = ox + lc;
			tw_c  = ({1'b0, ow} > lc) ? DIM_W'({1'b0, ow} - lc) : '0;
			div_c = (rt_q > k_idx) ? (rt_q - k_idx) : CNT_W'(1);
		end
		if (div_c == '0) begin
			div_c = CNT_W'(1);
		end
	end

	always_comb begin
		unique case (col_c)
			COL_LEFT:  used_sel = used_l_q;
			COL_RIGHT: used_sel = used_r_q;
			default:   used_sel = used_c_q;
		endcase
	end

	assign rem_c = ({1'b0, oh} > used_sel) ? DIM_W'({1'b0, oh} - used_sel) : '0;
	assign ty_c  = oy + used_sel;

	// Prepared tile and restoring divider.
	col_t               col_q;
	logic [COORD_W-1:0] tx_q, ty_q;
	logic [DIM_W-1:0]   tw_q;
	logic               oob_q, last_q;
	logic [QUOT_W-1:0]  num_q;
	logic [CNT_W-1:0]   den_q, r_q;
	logic [CNT_W:0]     trial;
	logic               qbit;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic               busy_q;
	logic [DIM_W-1:0]   th;

	assign trial = {r_q, num_q[QUOT_W-1]};
	assign qbit  = (trial >= {1'b0, den_q});
	assign th    = oob_q ? '0 : num_q;

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			col_q  <= col_c;
			tx_q   <= oob_c ? ox : tx_c;
			ty_q   <= oob_c ? oy : ty_c;
			tw_q   <= oob_c ? '0 : tw_c;
			oob_q  <= oob_c;
			last_q <= last_c;
			num_q  <= rem_c;
			den_q  <= div_c;
			r_q    <= '0;
		end else if (cmd.step) begin
			r_q   <= qbit ? CNT_W'(trial - {1'b0, den_q}) : trial[CNT_W-1:0];
			num_q <= {num_q[QUOT_W-2:0], qbit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (cmd.prep) begin
			cnt_q  <= DIV_CNT_W'(QUOT_W);
			busy_q <= 1'b1;
		end else if (cmd.step) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
		end else if (cmd.finish) begin
			busy_q <= 1'b0;
		end
	end

	// Layout state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			total_q  <= '0;
			lt_q     <= '0;
			rt_q     <= '0;
			cw_q     <= '0;
			lw_q     <= '0;
			used_c_q <= '0;
			used_l_q <= '0;
			used_r_q <= '0;
		end else if (cmd.latch) begin
			idx_q    <= '0;
			total_q  <= count_q;
			lt_q     <= lt_new;
			rt_q     <= stack_new - lt_new;
			cw_q     <= cw_new;
			lw_q     <= DIM_W'((ow - cw_new) >> 1);
			used_c_q <= '0;
			used_l_q <= '0;
			used_r_q <= '0;
		end else if (cmd.finish && !oob_q) begin
			idx_q <= idx_inc[CNT_W-1:0];
			unique case (col_q)
				COL_LEFT:  used_l_q <= used_l_q + {1'b0, th};
				COL_RIGHT: used_r_q <= used_r_q + {1'b0, th};
				default:   used_c_q <= used_c_q + {1'b0, th};
			endcase
		end
	end

	// Output register, restored to the caller's orientation.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			client_handle_out <= handle_q;
			last              <= last_q;
			if (portrait_q) begin
				tile_x      <= ty_q;
				tile_y      <= tx_q;
				tile_width  <= th;
				tile_height <= tw_q;
			end else begin
				tile_x      <= tx_q;
				tile_y      <= ty_q;
				tile_width  <= tw_q;
				tile_height <= th;
			end
		end
	end

	assign status.first    = first_q;
	assign status.oob      = oob_c;
	assign status.div_done = (cnt_q == '0);

	// The remainder left by the divider is below the divisor.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q == '0 && !oob_q) |-> (r_q < den_q))
		else $error("divider remainder not below divisor");

	// Used column heights stay inside the area height range.
	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		!used_c_q[COORD_W-1] && !used_l_q[COORD_W-1] && !used_r_q[COORD_W-1])
		else $error("column offset out of range");

	// The window index never runs past the latched total.
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= total_q)
		else $error("window index past arrangement");

endmodule

// ----- src/centered_master_tile_layout.sv -----
`timescale 1ns / 1ps
// Top level of the centered master tile layout block.
// Depends on cmt_pkg, cmt_ctrl and cmt_dp.

// Centered master tile layout. Windows of one arrangement arrive one word per
// item: a handle, the window count and a first flag that restarts the layout.
// Each word yields one word with the tile rectangle and a last flag. A window
// passes through the setup, prepare, divide and finish states before its result
// is registered; the first window of an arrangement also passes through a latch
// state, in which the layout widths and side counts are latched. The longest
// part is the tile height divider, which resolves one of its 15 quotient bits
// per cycle. A word that lies outside any arrangement skips the divider. The
// finish state waits while a stalled earlier result is still held at the output.
// Items are processed one at a time; the result sits in an output register,
// so the next item is accepted while an earlier result is still stalled at
// the output. The configuration channel is always ready, and registers must
// only be written while no item is in flight.

module centered_master_tile_layout import cmt_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	// Configuration write channel.
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	// Window channel.
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [HANDLE_W-1:0]        client_handle,
	input  logic [CNT_W-1:0]           client_count,
	input  logic                       first,
	// Tile channel.
	output logic                       tile_valid,
	input  logic                       tile_stall,
	output logic [HANDLE_W-1:0]        client_handle_out,
	output logic signed [COORD_W-1:0]  tile_x,
	output logic signed [COORD_W-1:0]  tile_y,
	output logic [DIM_W-1:0]           tile_width,
	output logic [DIM_W-1:0]           tile_height,
	output logic                       last
);

	cmt_cmd_t    cmd;
	cmt_status_t status;
	logic [COORD_W-1:0] tile_x_w, tile_y_w;

	// Change registers only between items (not enforced); writes never wait.
	assign cfg_ready = 1'b1;

	cmt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.tile_valid (tile_valid),
		.tile_stall (tile_stall),
		.cmd        (cmd),
		.status     (status)
	);

	cmt_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_valid),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.client_handle     (client_handle),
		.client_count      (client_count),
		.first             (first),
		.cmd               (cmd),
		.status            (status),
		.client_handle_out (client_handle_out),
		.tile_x            (tile_x_w),
		.tile_y            (tile_y_w),
		.tile_width        (tile_width),
		.tile_height       (tile_height),
		.last              (last)
	);

	// Coordinates wrap modulo the field width; the bits are passed as they are.
	assign tile_x = tile_x_w;
	assign tile_y = tile_y_w;

endmodule
